// ===== design/ihex_pkg.sv =====
// Shared constants for the Intel HEX record parser: field widths, result kinds,
// character codes and the hex digit decoder. No dependencies.
package ihex_pkg;

    localparam int ADDR_WIDTH = 16;
    localparam int KIND_WIDTH = 3;
    localparam int BYTE_WIDTH = 8;

    localparam logic [KIND_WIDTH-1:0] K_WRITE     = 3'd0;
    localparam logic [KIND_WIDTH-1:0] K_OK        = 3'd1;
    localparam logic [KIND_WIDTH-1:0] K_BADSUM    = 3'd2;
    localparam logic [KIND_WIDTH-1:0] K_EOF       = 3'd3;
    localparam logic [KIND_WIDTH-1:0] K_MALFORMED = 3'd4;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    localparam logic [7:0] REC_TYPE_EOF = 8'h01;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        case (c) inside
            [CH_0:CH_9]:   d.value = 4'(c - CH_0);
            [CH_UA:CH_UF]: d.value = 4'(c - CH_UA + 8'd10);
            [CH_LA:CH_LF]: d.value = 4'(c - CH_LA + 8'd10);
            default:       d.ok = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ===== design/ihex_parse.sv =====
// Record parser state machine: decodes one character per request and forms
// at most one result. Depends on ihex_pkg.
module ihex_parse #(
    parameter int ADDR_WIDTH = ihex_pkg::ADDR_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  logic [7:0]                        in_char,
    input  logic [ADDR_WIDTH:0]               mem_limit,
    output logic                              res_valid,
    output logic [ihex_pkg::KIND_WIDTH-1:0]   res_kind,
    output logic [ADDR_WIDTH-1:0]             res_addr,
    output logic [ihex_pkg::BYTE_WIDTH-1:0]   res_data
);
    import ihex_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_ADDR = 3'd2;
    localparam logic [2:0] PH_TYPE = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CSUM = 3'd5;

    logic [2:0]            phase_reg, phase_next;
    logic                  nibble_reg, nibble_next;
    logic [3:0]            high_reg, high_next;
    logic                  field_reg, field_next;
    logic [7:0]            len_reg, len_next;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    logic [7:0]            index_reg, index_next;
    logic [7:0]            sum_reg, sum_next;
    logic                  halted_reg, halted_next;

    hex_digit_t            digit;
    logic [7:0]            byte_val;
    logic [7:0]            sum_new;
    logic [7:0]            index_inc;
    logic [ADDR_WIDTH:0]   full_addr;

    always_comb
    begin
        digit     = hex_decode(in_char);
        byte_val  = {high_reg, digit.value};
        sum_new   = sum_reg + byte_val;
        index_inc = index_reg + 8'd1;
        full_addr = {1'b0, addr_reg} + (ADDR_WIDTH+1)'(index_reg);

        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        high_next   = high_reg;
        field_next  = field_reg;
        len_next    = len_reg;
        addr_next   = addr_reg;
        index_next  = index_reg;
        sum_next    = sum_reg;
        halted_next = halted_reg;
        res_valid   = 1'b0;
        res_kind    = K_WRITE;
        res_addr    = '0;
        res_data    = '0;

        if (fire && !halted_reg)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (in_char == CH_COLON)
                begin
                    phase_next  = PH_LEN;
                    nibble_next = 1'b0;
                    high_next   = 4'd0;
                    field_next  = 1'b0;
                    index_next  = 8'd0;
                    sum_next    = 8'd0;
                end
            end
            else if (!digit.ok)
            begin
                phase_next  = PH_IDLE;
                nibble_next = 1'b0;
                res_valid   = 1'b1;
                res_kind    = K_MALFORMED;
            end
            else if (!nibble_reg)
            begin
                high_next   = digit.value;
                nibble_next = 1'b1;
            end
            else
            begin
                nibble_next = 1'b0;
                sum_next    = sum_new;
                unique case (phase_reg)
                    PH_LEN:
                    begin
                        len_next   = byte_val;
                        field_next = 1'b0;
                        phase_next = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        if (!field_reg)
                        begin
                            addr_next  = ADDR_WIDTH'({byte_val, 8'h00});
                            field_next = 1'b1;
                        end
                        else
                        begin
                            addr_next  = addr_reg | ADDR_WIDTH'(byte_val);
                            field_next = 1'b0;
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        index_next = 8'd0;
                        if (byte_val == REC_TYPE_EOF)
                        begin
                            halted_next = 1'b1;
                            phase_next  = PH_IDLE;
                            res_valid   = 1'b1;
                            res_kind    = K_EOF;
                        end
                        else
                        begin
                            phase_next = (len_reg == 8'd0) ? PH_CSUM : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        index_next = index_inc;
                        if (index_inc == len_reg)
                        begin
                            phase_next = PH_CSUM;
                        end
                        if (full_addr < mem_limit && !full_addr[ADDR_WIDTH])
                        begin
                            res_valid = 1'b1;
                            res_kind  = K_WRITE;
                            res_addr  = full_addr[ADDR_WIDTH-1:0];
                            res_data  = byte_val;
                        end
                    end
                    PH_CSUM:
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        if (sum_new == 8'd0)
                        begin
                            res_kind = K_OK;
                        end
                        else
                        begin
                            res_kind    = K_BADSUM;
                            halted_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            nibble_reg <= 1'b0;
            high_reg   <= 4'd0;
            field_reg  <= 1'b0;
            len_reg    <= 8'd0;
            addr_reg   <= '0;
            index_reg  <= 8'd0;
            sum_reg    <= 8'd0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            high_reg   <= high_next;
            field_reg  <= field_next;
            len_reg    <= len_next;
            addr_reg   <= addr_next;
            index_reg  <= index_next;
            sum_reg    <= sum_next;
            halted_reg <= halted_next;
        end
    end

`ifndef SYNTH
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("parser left the halted state without reset");

    a_write_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_kind == K_WRITE) |-> (phase_reg == PH_DATA && nibble_reg))
        else $error("data write formed outside the data field");

    a_halt_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (!halted_reg && halted_next) |->
            (res_valid && (res_kind == K_EOF || res_kind == K_BADSUM)))
        else $error("parser halted without end of file or bad checksum");
`endif

endmodule

// ===== design/ihex_out_buf.sv =====
// Two-entry result buffer: output register plus skid register, so the parser
// keeps going while a result waits. Depends on ihex_pkg for house conventions.
module ihex_out_buf #(
    parameter int WIDTH = ihex_pkg::KIND_WIDTH + ihex_pkg::ADDR_WIDTH + ihex_pkg::BYTE_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import ihex_pkg::*;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [WIDTH-1:0] out_data_reg, out_data_next;
    logic [WIDTH-1:0] skid_data_reg, skid_data_next;
    logic             pop;

    always_comb
    begin
        pop             = out_valid_reg && out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full buffer");

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg
            && out_data_reg == $past(skid_data_reg)))
        else $error("skid entry not moved to output on pop");
`endif

endmodule

// ===== design/intel_hex_record_parser_core.sv =====
// Intel HEX record parser, top level: input register, parser, result buffer.
// The parser decodes each character held in the input register; its result is
// registered in the buffer's output register, or its skid register if that is busy.
// Throughput: one character per cycle while the buffer has space (single-pass parser).
// Reset (rst_n, asynchronous, active low) clears the parser and the buffers
// and sets the memory limit to 2^ADDR_WIDTH. Depends on ihex_parse, ihex_out_buf.
module intel_hex_record_parser_core #(
    parameter int ADDR_WIDTH = ihex_pkg::ADDR_WIDTH
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            s_axis_tvalid,
    output logic                                            s_axis_tready,
    input  logic [7:0]                                      s_axis_tdata, // in_char
    output logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready,
    // write_address, write_data
    output logic [((ADDR_WIDTH+ihex_pkg::BYTE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic [ihex_pkg::KIND_WIDTH-1:0]                 m_axis_tuser, // kind
    input  logic                                            cfg_valid,
    output logic                                            cfg_ready,
    input  logic [ADDR_WIDTH:0]                             cfg_data      // mem_limit
);
    import ihex_pkg::*;

    localparam int TDATA_W = ((ADDR_WIDTH + BYTE_WIDTH + 7) / 8) * 8;
    localparam int PAY_W   = KIND_WIDTH + ADDR_WIDTH + BYTE_WIDTH;

    logic [7:0]              char_reg;
    logic                    char_valid_reg, char_valid_next;
    logic [ADDR_WIDTH:0]     mem_limit_reg;
    logic                    fire;
    logic                    buf_space;
    logic                    res_valid;
    logic [KIND_WIDTH-1:0]   res_kind;
    logic [ADDR_WIDTH-1:0]   res_addr;
    logic [BYTE_WIDTH-1:0]   res_data;
    logic [PAY_W-1:0]        out_payload;

    assign fire          = char_valid_reg && buf_space;
    assign s_axis_tready = !char_valid_reg || fire;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        char_valid_next = char_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            char_valid_next = 1'b1;
        end
        else if (fire)
        begin
            char_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
            mem_limit_reg  <= (ADDR_WIDTH+1)'(1) << ADDR_WIDTH;
        end
        else
        begin
            char_valid_reg <= char_valid_next;
            if (cfg_valid)
            begin
                mem_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            char_reg <= s_axis_tdata;
        end
    end

    ihex_parse #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .in_char   (char_reg),
        .mem_limit (mem_limit_reg),
        .res_valid (res_valid),
        .res_kind  (res_kind),
        .res_addr  (res_addr),
        .res_data  (res_data)
    );

    ihex_out_buf #(
        .WIDTH (PAY_W)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire && res_valid),
        .push_data ({res_kind, res_data, res_addr}),
        .space     (buf_space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_payload)
    );

    assign m_axis_tuser = out_payload[PAY_W-1 -: KIND_WIDTH];
    assign m_axis_tdata = TDATA_W'(out_payload[ADDR_WIDTH+BYTE_WIDTH-1:0]);

endmodule
